// ===== rtl/bsm_pkg.sv =====
`timescale 1ns / 1ps
package bsm_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int GROWTH_WIDTH = 63;
  localparam logic [GROWTH_WIDTH-1:0] GROWTH_MAX = '1;
  localparam int AXES = 3;
endpackage

// ===== rtl/bsm_in_if.sv =====
`timescale 1ns / 1ps
interface bsm_in_if #(
  parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_center_x;
  logic signed [COORD_WIDTH-1:0] first_center_y;
  logic signed [COORD_WIDTH-1:0] first_center_z;
  logic        [COORD_WIDTH-2:0] first_radius;
  logic signed [COORD_WIDTH-1:0] second_center_x;
  logic signed [COORD_WIDTH-1:0] second_center_y;
  logic signed [COORD_WIDTH-1:0] second_center_z;
  logic        [COORD_WIDTH-2:0] second_radius;

  modport source (
    output valid, first_center_x, first_center_y, first_center_z, first_radius,
    output second_center_x, second_center_y, second_center_z, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_center_x, first_center_y, first_center_z, first_radius,
    input  second_center_x, second_center_y, second_center_z, second_radius,
    output ready
  );
endinterface

// ===== rtl/bsm_out_if.sv =====
`timescale 1ns / 1ps
interface bsm_out_if #(
  parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [COORD_WIDTH-1:0]         merged_center_x;
  logic signed [COORD_WIDTH-1:0]         merged_center_y;
  logic signed [COORD_WIDTH-1:0]         merged_center_z;
  logic        [COORD_WIDTH-2:0]         merged_radius;
  logic        [bsm_pkg::GROWTH_WIDTH-1:0] radius_growth;
  logic                                  spheres_overlap;

  modport source (
    output valid, merged_center_x, merged_center_y, merged_center_z, merged_radius,
    output radius_growth, spheres_overlap,
    input  ready
  );
  modport sink (
    input  valid, merged_center_x, merged_center_y, merged_center_z, merged_radius,
    input  radius_growth, spheres_overlap,
    output ready
  );
endinterface

// ===== rtl/bsm_mul.sv =====
`timescale 1ns / 1ps
module bsm_mul #(
  parameter int AW = bsm_pkg::COORD_WIDTH_DEF + 1,
  parameter int BW = bsm_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[AL-1:0] * b[BL-1:0];
      pp_lh <= a[AL-1:0] * b[BW-1:BL];
      pp_hl <= a[AW-1:AL] * b[BL-1:0];
      pp_hh <= a[AW-1:AL] * b[BW-1:BL];
      p     <= (PW'(pp_hh) << (AL + BL)) + (PW'(pp_lh) << BL)
             + (PW'(pp_hl) << AL) + PW'(pp_ll);
    end
  end
endmodule

// ===== rtl/bsm_div.sv =====
`timescale 1ns / 1ps
module bsm_div #(
  parameter int DW = bsm_pkg::COORD_WIDTH_DEF + 1,
  parameter int QW = bsm_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);
  logic [DW-1:0] rem  [QW-1];
  logic [QW-1:0] low  [QW-1];
  logic [DW-1:0] dv   [QW-1];
  logic [QW-1:0] qp   [QW];
  logic [DW-1:0] nrem [QW-1];
  logic [QW-1:0] nq   [QW];

  always_comb begin
    logic [DW:0] cand;
    logic        ge;
    nrem = '{default: '0};
    cand = {num[DW+QW-1:QW], num[QW-1]};
    ge = cand >= {1'b0, den};
    nrem[0] = ge ? DW'(cand - {1'b0, den}) : cand[DW-1:0];
    nq[0] = QW'(ge);
    for (int k = 1; k < QW; k++) begin
      cand = {rem[k-1], low[k-1][QW-1-k]};
      ge = cand >= {1'b0, dv[k-1]};
      if (k < QW - 1) begin
        nrem[k] = ge ? DW'(cand - {1'b0, dv[k-1]}) : cand[DW-1:0];
      end
      nq[k] = {qp[k-1][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nrem[0];
      low[0] <= num[QW-1:0];
      dv[0]  <= den;
      for (int k = 1; k < QW - 1; k++) begin
        rem[k] <= nrem[k];
        low[k] <= low[k-1];
        dv[k]  <= dv[k-1];
      end
      for (int k = 0; k < QW; k++) begin
        qp[k] <= nq[k];
      end
    end
  end

  assign quo = qp[QW-1];
endmodule

// ===== rtl/bounding_sphere_merge.sv =====
`timescale 1ns / 1ps
// One beat is accepted every cycle while the output is not stalled; the square
// root and the three dividers each retire one result bit per stage, and they set
// the depth of the pipeline. A stalled output holds the whole pipeline. Reset is
// synchronous and clears only the valid bits; data registers are not reset.
module bounding_sphere_merge #(
  parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bsm_in_if.sink    spheres,
  bsm_out_if.source merged
);
  localparam int CW  = COORD_WIDTH;
  localparam int RW  = CW - 1;
  localparam int MW  = CW + 1;
  localparam int DSW = 2 * MW;
  localparam int RM  = MW + 2;
  localparam int GW  = bsm_pkg::GROWTH_WIDTH;
  localparam int GXW = (DSW > GW + 1) ? DSW : GW + 1;
  localparam int NA  = bsm_pkg::AXES;

  localparam int ST_IN   = 1;
  localparam int ST_D    = 4;
  localparam int ST_CMP  = 5;
  localparam int ST_ROOT = ST_CMP + MW;
  localparam int ST_RA   = ST_ROOT + 1;
  localparam int ST_RB   = ST_RA + 1;
  localparam int ST_PROD = ST_RB + 2;
  localparam int ST_GROW = ST_PROD + 1;
  localparam int ST_QUO  = ST_PROD + MW;
  localparam int ST_OUT  = ST_QUO + 1;

  logic en;
  logic vld [ST_IN:ST_OUT];

  logic [CW-1:0] a_in [NA];
  logic [CW-1:0] b_in [NA];
  logic [CW:0]   dl_in [NA];

  logic [CW-1:0] a_p    [ST_IN:ST_QUO][NA];
  logic [CW-1:0] b_p    [ST_IN:ST_QUO][NA];
  logic          dneg_p [ST_IN:ST_QUO][NA];
  logic [MW-1:0] dmag_p [ST_IN:ST_RB][NA];
  logic [RW-1:0] r1_p   [ST_IN:ST_RB];
  logic [RW-1:0] r2_p   [ST_IN:ST_RB];
  logic          r1gt_p [ST_IN:ST_QUO];
  logic [CW-1:0] rsum;
  logic [RW-1:0] rdiff;

  logic [DSW-1:0]  sq [NA];
  logic [2*CW-1:0] sumsq;
  logic [2*RW-1:0] diffsq;
  logic [DSW-1:0]  dsq;
  logic [2*CW-1:0] sumsq_r;
  logic [2*RW-1:0] diffsq_r;
  logic [DSW-1:0]  dsq_c;
  logic            ovl_p  [ST_CMP:ST_QUO];
  logic            cont_p [ST_CMP:ST_QUO];

  logic [RM-1:0]  sq_rem   [MW-1];
  logic [MW-1:0]  sq_root  [MW];
  logic [DSW-1:0] sq_rad   [MW-1];
  logic [RM-1:0]  sq_rem_next  [MW-1];
  logic [MW-1:0]  sq_root_next [MW];

  logic [MW-1:0]   d_p [ST_RA:ST_PROD];
  logic [MW-1:0]   rraw;
  logic [MW-1:0]   frac;
  logic [MW-1:0]   rsel_p [ST_RB:ST_QUO];
  logic [DSW-1:0]  prod [NA];
  logic [DSW-1:0]  rsq;
  logic [2*RW-1:0] r1sq;
  logic [GW-1:0]   grow_p [ST_GROW:ST_QUO];
  logic [MW-1:0]   quo [NA];

  logic [CW-1:0] center_next [NA];
  logic [CW-1:0] center [NA];
  logic [RW-1:0] radius;
  logic [GW-1:0] growth;
  logic          overlap;

  assign en = !vld[ST_OUT] || merged.ready;
  assign spheres.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = ST_IN; k <= ST_OUT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[ST_IN] <= spheres.valid;
      for (int k = ST_IN + 1; k <= ST_OUT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    a_in[0] = spheres.first_center_x;
    a_in[1] = spheres.first_center_y;
    a_in[2] = spheres.first_center_z;
    b_in[0] = spheres.second_center_x;
    b_in[1] = spheres.second_center_y;
    b_in[2] = spheres.second_center_z;
    for (int g = 0; g < NA; g++) begin
      dl_in[g] = {b_in[g][CW-1], b_in[g]} - {a_in[g][CW-1], a_in[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NA; g++) begin
        a_p[ST_IN][g]    <= a_in[g];
        b_p[ST_IN][g]    <= b_in[g];
        dneg_p[ST_IN][g] <= dl_in[g][CW];
        dmag_p[ST_IN][g] <= dl_in[g][CW] ? MW'(-dl_in[g]) : dl_in[g];
      end
      r1_p[ST_IN]   <= spheres.first_radius;
      r2_p[ST_IN]   <= spheres.second_radius;
      r1gt_p[ST_IN] <= spheres.first_radius > spheres.second_radius;
      rsum  <= CW'(spheres.first_radius) + CW'(spheres.second_radius);
      rdiff <= (spheres.first_radius > spheres.second_radius)
             ? spheres.first_radius - spheres.second_radius
             : spheres.second_radius - spheres.first_radius;
      for (int k = ST_IN + 1; k <= ST_QUO; k++) begin
        a_p[k]    <= a_p[k-1];
        b_p[k]    <= b_p[k-1];
        dneg_p[k] <= dneg_p[k-1];
        r1gt_p[k] <= r1gt_p[k-1];
      end
      for (int k = ST_IN + 1; k <= ST_RB; k++) begin
        dmag_p[k] <= dmag_p[k-1];
        r1_p[k]   <= r1_p[k-1];
        r2_p[k]   <= r2_p[k-1];
      end
    end
  end

  for (genvar g = 0; g < NA; g++) begin : g_sq
    bsm_mul #(.AW(MW), .BW(MW)) u_sq (
      .clk(clk), .en(en), .a(dmag_p[ST_IN][g]), .b(dmag_p[ST_IN][g]), .p(sq[g])
    );
  end
  bsm_mul #(.AW(CW), .BW(CW)) u_sumsq (
    .clk(clk), .en(en), .a(rsum), .b(rsum), .p(sumsq)
  );
  bsm_mul #(.AW(RW), .BW(RW)) u_diffsq (
    .clk(clk), .en(en), .a(rdiff), .b(rdiff), .p(diffsq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dsq      <= sq[0] + sq[1] + sq[2];
      sumsq_r  <= sumsq;
      diffsq_r <= diffsq;
      dsq_c          <= dsq;
      ovl_p[ST_CMP]  <= DSW'(sumsq_r) > dsq;
      cont_p[ST_CMP] <= DSW'(diffsq_r) >= dsq;
      for (int k = ST_CMP + 1; k <= ST_QUO; k++) begin
        ovl_p[k]  <= ovl_p[k-1];
        cont_p[k] <= cont_p[k-1];
      end
    end
  end

  always_comb begin
    logic [RM+1:0] cand;
    logic [RM-1:0] trial;
    logic          ge;
    sq_rem_next = '{default: '0};
    cand  = {RM'(0), dsq_c[DSW-1 -: 2]};
    trial = {MW'(0), 2'b01};
    ge = cand >= (RM+2)'(trial);
    sq_rem_next[0]  = ge ? RM'(cand - (RM+2)'(trial)) : cand[RM-1:0];
    sq_root_next[0] = MW'(ge);
    for (int k = 1; k < MW; k++) begin
      cand  = {sq_rem[k-1], sq_rad[k-1][2*(MW-1-k) +: 2]};
      trial = {sq_root[k-1], 2'b01};
      ge = cand >= (RM+2)'(trial);
      if (k < MW - 1) begin
        sq_rem_next[k] = ge ? RM'(cand - (RM+2)'(trial)) : cand[RM-1:0];
      end
      sq_root_next[k] = {sq_root[k-1][MW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= sq_rem_next[0];
      sq_rad[0] <= dsq_c;
      for (int k = 1; k < MW - 1; k++) begin
        sq_rem[k] <= sq_rem_next[k];
        sq_rad[k] <= sq_rad[k-1];
      end
      for (int k = 0; k < MW; k++) begin
        sq_root[k] <= sq_root_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p[ST_RA] <= sq_root[MW-1];
      for (int k = ST_RA + 1; k <= ST_PROD; k++) begin
        d_p[k] <= d_p[k-1];
      end
      rraw <= MW'(((CW+2)'(sq_root[MW-1]) + (CW+2)'(r1_p[ST_ROOT])
                 + (CW+2)'(r2_p[ST_ROOT])) >> 1);
      frac <= rraw - MW'(r1_p[ST_RA]);
      rsel_p[ST_RB] <= cont_p[ST_RA]
                     ? (r1gt_p[ST_RA] ? MW'(r1_p[ST_RA]) : MW'(r2_p[ST_RA]))
                     : rraw;
      for (int k = ST_RB + 1; k <= ST_QUO; k++) begin
        rsel_p[k] <= rsel_p[k-1];
      end
    end
  end

  for (genvar g = 0; g < NA; g++) begin : g_prod
    bsm_mul #(.AW(MW), .BW(MW)) u_prod (
      .clk(clk), .en(en), .a(dmag_p[ST_RB][g]), .b(frac), .p(prod[g])
    );
    bsm_div #(.DW(MW), .QW(MW)) u_div (
      .clk(clk), .en(en), .num(prod[g]), .den(d_p[ST_PROD]), .quo(quo[g])
    );
  end
  bsm_mul #(.AW(MW), .BW(MW)) u_rsq (
    .clk(clk), .en(en), .a(rsel_p[ST_RB]), .b(rsel_p[ST_RB]), .p(rsq)
  );
  bsm_mul #(.AW(RW), .BW(RW)) u_r1sq (
    .clk(clk), .en(en), .a(r1_p[ST_RB]), .b(r1_p[ST_RB]), .p(r1sq)
  );

  always_ff @(posedge clk) begin
    logic [GXW-1:0] gx;
    if (en) begin
      gx = GXW'(rsq - DSW'(r1sq));
      grow_p[ST_GROW] <= (gx > GXW'(bsm_pkg::GROWTH_MAX)) ? bsm_pkg::GROWTH_MAX : gx[GW-1:0];
      for (int k = ST_GROW + 1; k <= ST_QUO; k++) begin
        grow_p[k] <= grow_p[k-1];
      end
    end
  end

  always_comb begin
    logic [CW+1:0] cs;
    for (int g = 0; g < NA; g++) begin
      if (dneg_p[ST_QUO][g]) begin
        cs = {{2{a_p[ST_QUO][g][CW-1]}}, a_p[ST_QUO][g]} - {1'b0, quo[g]};
      end else begin
        cs = {{2{a_p[ST_QUO][g][CW-1]}}, a_p[ST_QUO][g]} + {1'b0, quo[g]};
      end
      if (cont_p[ST_QUO]) begin
        center_next[g] = r1gt_p[ST_QUO] ? a_p[ST_QUO][g] : b_p[ST_QUO][g];
      end else if (cs[CW+1:CW-1] == 3'b000 || cs[CW+1:CW-1] == 3'b111) begin
        center_next[g] = cs[CW-1:0];
      end else if (cs[CW+1]) begin
        center_next[g] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        center_next[g] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      center  <= center_next;
      radius  <= (rsel_p[ST_QUO][MW-1:RW] != 2'b00) ? {RW{1'b1}} : rsel_p[ST_QUO][RW-1:0];
      growth  <= grow_p[ST_QUO];
      overlap <= ovl_p[ST_QUO];
    end
  end

  assign merged.valid           = vld[ST_OUT];
  assign merged.merged_center_x = center[0];
  assign merged.merged_center_y = center[1];
  assign merged.merged_center_z = center[2];
  assign merged.merged_radius   = radius;
  assign merged.radius_growth   = growth;
  assign merged.spheres_overlap = overlap;
endmodule

// ===== bench/bounding_sphere_merge_test.sv =====
`timescale 1ns / 1ps
module bounding_sphere_merge_test;

  localparam int W = bsm_pkg::COORD_WIDTH_DEF;
  localparam int LATENCY = 2 * W + 12;

  typedef struct packed {
    logic signed [W-1:0] ax, ay, az;
    logic [W-2:0]        ar;
    logic signed [W-1:0] bx, by, bz;
    logic [W-2:0]        br;
  } sphere_pair_t;

  typedef struct packed {
    logic signed [W-1:0]              cx, cy, cz;
    logic [W-2:0]                     rad;
    logic [bsm_pkg::GROWTH_WIDTH-1:0] growth;
    logic                             overlap;
  } merge_result_t;

  class merge_scoreboard;
    merge_result_t pending[$];
    int errors = 0;

    function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] res;
      logic [63:0] c;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
        c = res | (64'd1 << b);
        if (128'(c) * 128'(c) <= v) res = c;
      end
      return res;
    endfunction

    function automatic merge_result_t merge(sphere_pair_t p);
      merge_result_t m;
      logic signed [W:0] dl [3];
      logic signed [W+1:0] a [3];
      logic signed [W+1:0] ctr [3];
      logic [W:0] mag [3];
      logic [127:0] dsq, sum2, diff2, q, g;
      logic [63:0] r1, r2, diff, rad, d, frac;
      dsq = 0;
      a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
      dl[0] = p.bx - p.ax; dl[1] = p.by - p.ay; dl[2] = p.bz - p.az;
      for (int k = 0; k < 3; k++) begin
        mag[k] = dl[k] < 0 ? -dl[k] : dl[k];
        dsq += 128'(mag[k]) * 128'(mag[k]);
      end
      r1 = p.ar; r2 = p.br;
      diff = r1 > r2 ? r1 - r2 : r2 - r1;
      sum2 = 128'(r1 + r2) * 128'(r1 + r2);
      diff2 = 128'(diff) * 128'(diff);
      m.overlap = dsq < sum2;
      if (diff2 >= dsq) begin
        rad = r1 > r2 ? r1 : r2;
        if (r1 > r2) begin
          ctr[0] = p.ax; ctr[1] = p.ay; ctr[2] = p.az;
        end else begin
          ctr[0] = p.bx; ctr[1] = p.by; ctr[2] = p.bz;
        end
      end else begin
        d = isqrt(dsq);
        rad = (d + r1 + r2) >> 1;
        frac = rad - r1;
        for (int k = 0; k < 3; k++) begin
          q = d == 0 ? 0 : (128'(mag[k]) * 128'(frac)) / 128'(d);
          if (q > (128'd1 << 62)) q = 128'd1 << 62;
          ctr[k] = dl[k] < 0 ? a[k] - $signed({1'b0, q[W:0]}) : a[k] + $signed({1'b0, q[W:0]});
        end
      end
      for (int k = 0; k < 3; k++) begin
        if (ctr[k] > $signed({3'b0, {(W-1){1'b1}}})) ctr[k] = {3'b0, {(W-1){1'b1}}};
        if (ctr[k] < -$signed({3'b0, {(W-1){1'b1}}}) - 1) ctr[k] = {3'b111, {(W-1){1'b0}}};
      end
      m.cx = ctr[0][W-1:0]; m.cy = ctr[1][W-1:0]; m.cz = ctr[2][W-1:0];
      m.rad = rad > {(W-1){1'b1}} ? {(W-1){1'b1}} : rad[W-2:0];
      g = 128'(rad) * 128'(rad) - 128'(r1) * 128'(r1);
      m.growth = g > 128'(bsm_pkg::GROWTH_MAX) ? bsm_pkg::GROWTH_MAX
                                                : g[bsm_pkg::GROWTH_WIDTH-1:0];
      return m;
    endfunction

    function void note_pair(sphere_pair_t p);
      pending.push_back(merge(p));
    endfunction

    function void check_result(merge_result_t got);
      merge_result_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cx !== want.cx) begin
        $display("%0t center x expected %h got %h", $time, want.cx, got.cx); errors++;
      end
      if (got.cy !== want.cy) begin
        $display("%0t center y expected %h got %h", $time, want.cy, got.cy); errors++;
      end
      if (got.cz !== want.cz) begin
        $display("%0t center z expected %h got %h", $time, want.cz, got.cz); errors++;
      end
      if (got.rad !== want.rad) begin
        $display("%0t radius expected %h got %h", $time, want.rad, got.rad); errors++;
      end
      if (got.growth !== want.growth) begin
        $display("%0t growth expected %h got %h", $time, want.growth, got.growth); errors++;
      end
      if (got.overlap !== want.overlap) begin
        $display("%0t overlap expected %b got %b", $time, want.overlap, got.overlap); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bsm_in_if #(.COORD_WIDTH(W)) spheres ();
  bsm_out_if #(.COORD_WIDTH(W)) merged ();
  merge_scoreboard board = new();
  bit sending_done = 0;

  bounding_sphere_merge #(.COORD_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .spheres(spheres.sink), .merged(merged.source)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    spheres.valid = 0;
    {spheres.first_center_x, spheres.first_center_y, spheres.first_center_z,
     spheres.first_radius, spheres.second_center_x, spheres.second_center_y,
     spheres.second_center_z, spheres.second_radius} = '0;
    merged.ready = 0;
  end

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2: return W'($signed($urandom_range(0, 2000)) - 1000);
      3: return W'($signed($urandom_range(0, 32'h00A00000)) - 32'h00500000);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-2:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return '0;
      2: return (W-1)'($urandom_range(0, 32'h00400000));
      default: return (W-1)'($urandom);
    endcase
  endfunction

  function automatic sphere_pair_t rand_pair();
    sphere_pair_t p;
    p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord(); p.ar = rand_radius();
    case ($urandom_range(0, 4))
      0: begin
        p.bx = p.ax; p.by = p.ay; p.bz = p.az;
        p.br = $urandom_range(0, 1) ? p.ar : rand_radius();
      end
      1: begin
        p.bx = p.ax + W'($signed($urandom_range(0, 200)) - 100);
        p.by = p.ay + W'($signed($urandom_range(0, 200)) - 100);
        p.bz = p.az + W'($signed($urandom_range(0, 200)) - 100);
        p.br = rand_radius();
      end
      default: begin
        p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord(); p.br = rand_radius();
      end
    endcase
    return p;
  endfunction

  task automatic send_pair(sphere_pair_t p);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      spheres.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    spheres.valid <= 1;
    {spheres.first_center_x, spheres.first_center_y, spheres.first_center_z,
     spheres.first_radius, spheres.second_center_x, spheres.second_center_y,
     spheres.second_center_z, spheres.second_radius} <= p;
    do @(posedge clk); while (!spheres.ready);
    board.note_pair(p);
  endtask

  initial begin
    sphere_pair_t directed[$];
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    directed.push_back('0);
    directed.push_back({mx, mx, mx, {(W-1){1'b1}}, mx, mx, mx, {(W-1){1'b1}}});
    directed.push_back({mn, mn, mn, {(W-1){1'b1}}, mx, mx, mx, {(W-1){1'b1}}});
    directed.push_back({mx, mx, mx, {(W-1){1'b0}}, mn, mn, mn, {(W-1){1'b0}}});
    directed.push_back({mn, mx, mn, {(W-1){1'b1}}, mx, mn, mx, {(W-1){1'b0}}});
    directed.push_back({32'h10000, 32'h0, 32'h0, 31'h50000, 32'h0, 32'h0, 32'h0, 31'h10000});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h10000, 32'h10000, 32'h0, 32'h0, 31'h50000});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h20000, 32'h0, 32'h0, 32'h0, 31'h20000});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h10000, 32'h40000, 32'h0, 32'h0, 31'h10000});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h10000, 32'h20000, 32'h0, 32'h0, 31'h10000});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h10000, 32'hFFFE0000, 32'h30000, 32'h0, 31'h8000});
    directed.push_back({mn, 32'h0, 32'h0, 31'h0, mx, 32'h0, 32'h0, 31'h0});
    directed.push_back({32'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 32'h1, 31'h0});
    repeat (8) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_pair(directed[i]);
    for (int n = 0; n < 900; n++) begin
      if (n == 450) begin
        spheres.valid <= 0;
        wait (board.pending.size() == 0);
      end
      send_pair(rand_pair());
    end
    spheres.valid <= 0;
    sending_done = 1;
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        merged.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      merged.ready <= 1;
      do @(posedge clk); while (!merged.valid);
      board.check_result({merged.merged_center_x, merged.merged_center_y,
                          merged.merged_center_z, merged.merged_radius,
                          merged.radius_growth, merged.spheres_overlap});
    end
  end

  initial begin
    wait (sending_done && board.pending.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bsm_pkg.sv
rtl/bsm_in_if.sv
rtl/bsm_out_if.sv
rtl/bsm_mul.sv
rtl/bsm_div.sv
rtl/bounding_sphere_merge.sv
bench/bounding_sphere_merge_test.sv
